// File: rtl/lct_pkg.sv
// shared types and constants for the lru cache tag manager
// no dependencies; used by the controller, the datapath, the top level and the checker
package lct_pkg;

    // fixed payload widths
    localparam int KEY_W  = 64;
    localparam int SLOT_W = 5;

    // opcode values
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic start;        // latch key, rewind scan, reset trackers
        logic scan_step;    // issue key read at scan index, advance
        logic cmp_en;       // evaluate entry returned by previous read
        logic rd_victim;    // read key of victim slot
        logic commit_hit;   // refresh found slot, load hit result
        logic commit_free;  // fill free slot, load miss result
        logic commit_evict; // replace victim, load eviction result
        logic clear_all;    // drop all entries, load zero result
    } lct_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic rd_last;      // scan index sits on last slot
        logic found;        // key matched a valid entry
        logic free_found;   // an invalid slot exists
    } lct_status_t;

endpackage

// File: rtl/lct_ctrl.sv
// sequencing state machine for the lru cache tag manager
// depends on lct_pkg; drives lct_datapath through lct_cmd_t
module lct_ctrl
    import lct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    output logic        out_valid,
    input  logic        out_stall,
    output lct_cmd_t    cmd,
    input  lct_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_DECIDE,
        ST_EVRD,
        ST_CLEAR
    } state_t;

    state_t state_reg, state_next;
    logic   pipe_reg, pipe_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   commit;

    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = cmd.commit_hit || cmd.commit_free || cmd.commit_evict || cmd.clear_all;

    always_comb
    begin
        state_next = state_reg;
        pipe_next  = 1'b0;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (opcode == OP_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.cmp_en    = pipe_reg;
                pipe_next     = 1'b1;
                if (status.rd_last)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                cmd.cmp_en = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (status.found)
                begin
                    if (out_free)
                    begin
                        cmd.commit_hit = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (status.free_found)
                begin
                    if (out_free)
                    begin
                        cmd.commit_free = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_victim = 1'b1;
                    state_next    = ST_EVRD;
                end
            end
            ST_EVRD:
            begin
                if (out_free)
                begin
                    cmd.commit_evict = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (out_free)
                begin
                    cmd.clear_all = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && out_stall) || commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pipe_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pipe_reg      <= pipe_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/lct_datapath.sv
// tag memory, valid/age registers, scan trackers and result register
// depends on lct_pkg; commanded by lct_ctrl
module lct_datapath
    import lct_pkg::*;
#(
    parameter int CAPACITY = 20,
    parameter int KEY_BITS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lct_cmd_t           cmd,
    output lct_status_t        status,
    input  logic [KEY_W-1:0]   key,
    output logic               hit,
    output logic [SLOT_W-1:0]  slot,
    output logic               evicted,
    output logic [KEY_W-1:0]   evicted_key
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int AW = $clog2(CAPACITY + 1);

    // tag memory, one read port with registered data
    logic [KEY_BITS-1:0] key_mem [CAPACITY];

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] rd_data_reg;
    logic [IW-1:0]       rd_idx_reg;
    logic [IW-1:0]       cmp_idx_reg;
    logic [IW-1:0]       rd_addr;

    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [AW-1:0]       age_reg  [CAPACITY];
    logic [AW-1:0]       age_next [CAPACITY];

    logic                found_reg;
    logic [IW-1:0]       found_idx_reg;
    logic                free_reg;
    logic [IW-1:0]       free_idx_reg;
    logic                vict_reg;
    logic [IW-1:0]       vict_idx_reg;
    logic [AW-1:0]       vict_age_reg;

    logic                hit_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                evicted_reg;
    logic [KEY_W-1:0]    evicted_key_reg;

    logic                cur_valid;
    logic [AW-1:0]       cur_age;
    logic                key_eq;
    logic                commit;
    logic [IW-1:0]       tgt_idx;
    logic [AW-1:0]       old_age;

    assign rd_addr   = cmd.rd_victim ? vict_idx_reg : rd_idx_reg;
    assign cur_valid = valid_reg[cmp_idx_reg];
    assign cur_age   = age_reg[cmp_idx_reg];
    assign key_eq    = (rd_data_reg == key_reg);
    assign commit    = cmd.commit_hit || cmd.commit_free || cmd.commit_evict;

    assign tgt_idx = cmd.commit_hit  ? found_idx_reg :
                     cmd.commit_free ? free_idx_reg  : vict_idx_reg;
    assign old_age = valid_reg[tgt_idx] ? age_reg[tgt_idx] : AW'(CAPACITY);

    // move-to-front: entries newer than the target age by one; clear_all drops all entries
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            valid_next[i] = valid_reg[i];
            age_next[i]   = age_reg[i];
            if (cmd.clear_all)
            begin
                valid_next[i] = 1'b0;
                age_next[i]   = '0;
            end
            else if (commit)
            begin
                if (IW'(i) == tgt_idx)
                begin
                    valid_next[i] = 1'b1;
                    age_next[i]   = '0;
                end
                else if (valid_reg[i] && (age_reg[i] < old_age))
                begin
                    age_next[i] = AW'(age_reg[i] + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit_free || cmd.commit_evict)
        begin
            key_mem[tgt_idx] <= key_reg;
        end
        if (cmd.scan_step || cmd.rd_victim)
        begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                age_reg[i] <= '0;
            end
            rd_idx_reg    <= '0;
            cmp_idx_reg   <= '0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            vict_reg      <= 1'b0;
            vict_idx_reg  <= '0;
            vict_age_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < CAPACITY; i++)
            begin
                age_reg[i] <= age_next[i];
            end
            if (cmd.start)
            begin
                rd_idx_reg <= '0;
                found_reg  <= 1'b0;
                free_reg   <= 1'b0;
                vict_reg   <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                cmp_idx_reg <= rd_idx_reg;
                rd_idx_reg  <= IW'(rd_idx_reg + 1'b1);
            end
            if (cmd.cmp_en)
            begin
                if (cur_valid)
                begin
                    if (!found_reg && key_eq)
                    begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= cmp_idx_reg;
                    end
                    // first entry with the strictly greatest age wins
                    if (!vict_reg || (cur_age > vict_age_reg))
                    begin
                        vict_reg     <= 1'b1;
                        vict_idx_reg <= cmp_idx_reg;
                        vict_age_reg <= cur_age;
                    end
                end
                else if (!free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= cmp_idx_reg;
                end
            end
        end
    end

    // key register, and result register loaded only when the output side is free
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= key[KEY_BITS-1:0];
        end
        if (cmd.clear_all)
        begin
            hit_reg         <= 1'b0;
            slot_reg        <= '0;
            evicted_reg     <= 1'b0;
            evicted_key_reg <= '0;
        end
        else if (commit)
        begin
            hit_reg         <= cmd.commit_hit;
            slot_reg        <= SLOT_W'(tgt_idx);
            evicted_reg     <= cmd.commit_evict;
            evicted_key_reg <= cmd.commit_evict ? KEY_W'(rd_data_reg) : '0;
        end
    end

    assign status.rd_last    = (rd_idx_reg == IW'(CAPACITY - 1));
    assign status.found      = found_reg;
    assign status.free_found = free_reg;

    assign hit         = hit_reg;
    assign slot        = slot_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

endmodule

// File: rtl/lru_cache_tag_manager.sv
// lookup: a scan of the tag memory at one entry per cycle, then a decision; a hit or a
// free-slot fill commits from there, an eviction first reads the victim key; each commit waits for a free output
// clear: drops all entries once the output is free; one transaction in flight, result held in an output
// register so the next transaction is taken while the result waits
// reset (rst_n, async low) drops all valid bits and ages at once; no clearing sweep,
// tag memory contents stay undefined until written
//
// top level: joins lct_ctrl and lct_datapath; depends on lct_pkg
module lru_cache_tag_manager
    import lct_pkg::*;
#(
    parameter int CAPACITY = 20,
    parameter int KEY_BITS = 64
) (
    input  logic               clk,
    input  logic               rst_n,

    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [KEY_W-1:0]   key,

    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic [SLOT_W-1:0]  slot,
    output logic               evicted,
    output logic [KEY_W-1:0]   evicted_key
);

    lct_cmd_t    cmd;
    lct_status_t status;

    // controller: idle / scan / tail / decide / victim read / clear
    // in_stall is low only in idle; the scan runs one slot per cycle, each
    // compare lagging its read step by the registered tag read
    lct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath: tag memory, per-slot valid and age (0 = most recent),
    // match / free-slot / oldest trackers, move-to-front update, result register
    lct_datapath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .key         (key),
        .hit         (hit),
        .slot        (slot),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

endmodule

// File: rtl/lct_checker.sv
// port-level checks for the lru cache tag manager, bound to the top level
// depends on lct_pkg widths
module lct_checker
    import lct_pkg::*;
#(
    parameter int CAPACITY = 20
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               hit,
    input logic [SLOT_W-1:0]  slot,
    input logic               evicted,
    input logic [KEY_W-1:0]   evicted_key
);

    // a held result keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(slot)
            && $stable(evicted) && $stable(evicted_key))
        else $error("result changed while stalled");

    // one transaction at a time: after an accept the request side stalls
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction taken while busy");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !evicted)
        else $error("hit with eviction");

    // evicted key is zero without an eviction
    a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted |-> evicted_key == '0)
        else $error("stray evicted key");

    // a hit names a real slot
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> slot < CAPACITY)
        else $error("hit slot out of range");

endmodule

bind lru_cache_tag_manager lct_checker #(
    .CAPACITY (CAPACITY)
) u_lct_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .slot        (slot),
    .evicted     (evicted),
    .evicted_key (evicted_key)
);
